### src/spbw_pkg.sv
`timescale 1ns / 1ps
package spbw_pkg;

   localparam int POS_W         = 32;
   localparam int LEN_W         = 31;
   localparam int YZ_W          = POS_W + 1;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int MAX_WRAPS_DEF = 4;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [CSR_IDX_W-1:0] REG_BOX_LEN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_LEN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_LEN_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHEAR_AXIS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHEAR_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TWO_DIM_MODE = 3'd5;

   localparam logic [1:0] SHEAR_ON_Y = 2'd1;
   localparam logic [1:0] SHEAR_ON_Z = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP_X1,
      ST_WRAP_Y,
      ST_WRAP_Z,
      ST_WRAP_X2,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic     load;
      logic     step;
      axis_type axis;
      logic     set_flag;
      logic     push;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic shifted;
      logic two_dim;
   } status_type;

endpackage

### src/spbw_if.sv
`timescale 1ns / 1ps
interface spbw_req_if;
   import spbw_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic                    last_particle;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output last_particle, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input last_particle, output ready);
endinterface

interface spbw_rsp_if;
   import spbw_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] wrapped_x;
   logic signed [POS_W-1:0] wrapped_y;
   logic signed [POS_W-1:0] wrapped_z;
   logic                    out_of_reach;
   logic                    last_out;

   modport source (output valid, output wrapped_x, output wrapped_y, output wrapped_z,
                   output out_of_reach, output last_out, input ready);
   modport sink   (input valid, input wrapped_x, input wrapped_y, input wrapped_z,
                   input out_of_reach, input last_out, output ready);
endinterface

### src/spbw_ctrl.sv
`timescale 1ns / 1ps
module spbw_ctrl #(
   parameter int MAX_WRAPS = spbw_pkg::MAX_WRAPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output spbw_pkg::cmd_type    cmd,
   input  spbw_pkg::status_type status
);
   import spbw_pkg::*;

   localparam int CW = $clog2(MAX_WRAPS + 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(MAX_WRAPS);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          phase_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign phase_end = status.in_range || (cnt_ff == CNT_LAST);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.axis     = AXIS_X;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_WRAP_X1;
            end
         end
         ST_WRAP_X1, ST_WRAP_Y, ST_WRAP_Z, ST_WRAP_X2: begin
            case (state_ff)
               ST_WRAP_Y: cmd.axis = AXIS_Y;
               ST_WRAP_Z: cmd.axis = AXIS_Z;
               default:   cmd.axis = AXIS_X;
            endcase
            if (phase_end) begin
               cmd.set_flag = !status.in_range;
               cnt_in       = '0;
               case (state_ff)
                  ST_WRAP_X1: state_in = ST_WRAP_Y;
                  ST_WRAP_Y: begin
                     if (!status.two_dim)    state_in = ST_WRAP_Z;
                     else if (status.shifted) state_in = ST_WRAP_X2;
                     else                     state_in = ST_DONE;
                  end
                  ST_WRAP_Z: state_in = status.shifted ? ST_WRAP_X2 : ST_DONE;
                  default:   state_in = ST_DONE;
               endcase
            end else begin
               cmd.step = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.push     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/spbw_dp.sv
`timescale 1ns / 1ps
module spbw_dp #(
   parameter int MAX_WRAPS = spbw_pkg::MAX_WRAPS_DEF,
   parameter int FRAC_BITS = spbw_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [spbw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [spbw_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [spbw_pkg::POS_W-1:0]     pos_x,
   input  logic signed [spbw_pkg::POS_W-1:0]     pos_y,
   input  logic signed [spbw_pkg::POS_W-1:0]     pos_z,
   input  logic                                  last_particle,
   input  spbw_pkg::cmd_type                     cmd,
   output spbw_pkg::status_type                  status,
   output logic signed [spbw_pkg::POS_W-1:0]     wrapped_x,
   output logic signed [spbw_pkg::POS_W-1:0]     wrapped_y,
   output logic signed [spbw_pkg::POS_W-1:0]     wrapped_z,
   output logic                                  out_of_reach,
   output logic                                  last_out
);
   import spbw_pkg::*;

   // x holds the first wrap plus up to MAX_WRAPS shear offsets
   localparam int CW = $clog2(MAX_WRAPS + 1);
   localparam int XW = POS_W + 1 + CW;
   localparam logic [LEN_W-1:0] BOX_RESET = LEN_W'(1) << FRAC_BITS;
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   logic [LEN_W-1:0]        len_x_ff, len_y_ff, len_z_ff;
   logic [1:0]              shear_axis_ff;
   logic signed [POS_W-1:0] shear_off_ff;
   logic                    two_dim_ff;

   logic signed [XW-1:0]    x_ff;
   logic signed [YZ_W-1:0]  y_ff, z_ff;
   logic                    flag_ff, shifted_ff, last_ff;

   logic signed [POS_W-1:0] wx_ff, wy_ff, wz_ff;
   logic                    reach_ff, lastout_ff;

   logic signed [XW-1:0]    val_sel, len_sel, off_ext;
   logic                    shear_y, shear_z, neg_sel;
   logic signed [POS_W-1:0] x_sat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_x_ff      <= BOX_RESET;
         len_y_ff      <= BOX_RESET;
         len_z_ff      <= BOX_RESET;
         shear_axis_ff <= '0;
         shear_off_ff  <= '0;
         two_dim_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BOX_LEN_X:    len_x_ff      <= csr_wdata[LEN_W-1:0];
            REG_BOX_LEN_Y:    len_y_ff      <= csr_wdata[LEN_W-1:0];
            REG_BOX_LEN_Z:    len_z_ff      <= csr_wdata[LEN_W-1:0];
            REG_SHEAR_AXIS:   shear_axis_ff <= csr_wdata[1:0];
            REG_SHEAR_OFFSET: shear_off_ff  <= csr_wdata[POS_W-1:0];
            REG_TWO_DIM_MODE: two_dim_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign shear_y = (shear_axis_ff == SHEAR_ON_Y);
   assign shear_z = (shear_axis_ff == SHEAR_ON_Z) && !two_dim_ff;
   assign off_ext = {{(XW-POS_W){shear_off_ff[POS_W-1]}}, shear_off_ff};

   always_comb begin
      case (cmd.axis)
         AXIS_Y: begin
            val_sel = {{(XW-YZ_W){y_ff[YZ_W-1]}}, y_ff};
            len_sel = {{(XW-LEN_W){1'b0}}, len_y_ff};
         end
         AXIS_Z: begin
            val_sel = {{(XW-YZ_W){z_ff[YZ_W-1]}}, z_ff};
            len_sel = {{(XW-LEN_W){1'b0}}, len_z_ff};
         end
         default: begin
            val_sel = x_ff;
            len_sel = {{(XW-LEN_W){1'b0}}, len_x_ff};
         end
      endcase
   end

   assign neg_sel         = val_sel[XW-1];
   assign status.in_range = !neg_sel && (val_sel < len_sel);
   assign status.shifted  = shifted_ff;
   assign status.two_dim  = two_dim_ff;

   // working registers: one wrap step per cycle on the selected axis while cmd.step is set
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff       <= {{(XW-POS_W){pos_x[POS_W-1]}}, pos_x};
         y_ff       <= {pos_y[POS_W-1], pos_y};
         z_ff       <= {pos_z[POS_W-1], pos_z};
         flag_ff    <= 1'b0;
         shifted_ff <= 1'b0;
         last_ff    <= last_particle;
      end else begin
         if (cmd.set_flag) flag_ff <= 1'b1;
         if (cmd.step) begin
            case (cmd.axis)
               AXIS_Y: begin
                  y_ff <= neg_sel ? y_ff + YZ_W'(len_sel) : y_ff - YZ_W'(len_sel);
                  if (shear_y) begin
                     x_ff       <= neg_sel ? x_ff + off_ext : x_ff - off_ext;
                     shifted_ff <= 1'b1;
                  end
               end
               AXIS_Z: begin
                  z_ff <= neg_sel ? z_ff + YZ_W'(len_sel) : z_ff - YZ_W'(len_sel);
                  if (shear_z) begin
                     x_ff       <= neg_sel ? x_ff + off_ext : x_ff - off_ext;
                     shifted_ff <= 1'b1;
                  end
               end
               default: x_ff <= neg_sel ? x_ff + len_sel : x_ff - len_sel;
            endcase
         end
      end
   end

   // saturate x when the upper bits are not a sign extension
   always_comb begin
      if (x_ff[XW-1:POS_W-1] == '0 || x_ff[XW-1:POS_W-1] == '1) begin
         x_sat = x_ff[POS_W-1:0];
      end else begin
         x_sat = x_ff[XW-1] ? POS_MIN : POS_MAX;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         wx_ff      <= x_sat;
         wy_ff      <= y_ff[POS_W-1:0];
         wz_ff      <= z_ff[POS_W-1:0];
         reach_ff   <= flag_ff;
         lastout_ff <= last_ff;
      end
   end

   assign wrapped_x    = wx_ff;
   assign wrapped_y    = wy_ff;
   assign wrapped_z    = wz_ff;
   assign out_of_reach = reach_ff;
   assign last_out     = lastout_ff;

endmodule

### src/sheared_periodic_box_wrap.sv
`timescale 1ns / 1ps
// Operation: each accepted word runs its axis phases in turn (x, y, z, no z in
//   2-D mode, plus the repair x wrap after a shear step), each of add/subtract steps; 4 phases at most in 3-D.
// Flow: one word at a time, set by the single sequencer; a stalled result word holds the
//   next in done.
// Reset: synchronous, active high; box lengths return to 1.0, shear and 2-D mode off,
//   no word in flight. No memories, so no clearing pass.
module sheared_periodic_box_wrap #(
   parameter int MAX_WRAPS = spbw_pkg::MAX_WRAPS_DEF,
   parameter int FRAC_BITS = spbw_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   spbw_req_if.sink                        req_if,
   spbw_rsp_if.source                      rsp_if,
   input  logic                            csr_wr_en,
   input  logic [spbw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spbw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spbw_pkg::*;

   // command / status between the sequencer and the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: idle -> x wrap -> y wrap -> z wrap (skipped in 2-D mode) -> optional repair x wrap -> done
   spbw_ctrl #(
      .MAX_WRAPS (MAX_WRAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: config registers, working coordinates, output word register
   spbw_dp #(
      .MAX_WRAPS (MAX_WRAPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pos_x         (req_if.pos_x),
      .pos_y         (req_if.pos_y),
      .pos_z         (req_if.pos_z),
      .last_particle (req_if.last_particle),
      .cmd           (cmd),
      .status        (status),
      .wrapped_x     (rsp_if.wrapped_x),
      .wrapped_y     (rsp_if.wrapped_y),
      .wrapped_z     (rsp_if.wrapped_z),
      .out_of_reach  (rsp_if.out_of_reach),
      .last_out      (rsp_if.last_out)
   );

endmodule

### src/spbw_checker.sv
`timescale 1ns / 1ps
module spbw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] wrapped_y
);

   // output word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(wrapped_y))
      else $error("rsp word dropped or changed while stalled");

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while busy");

   // no result can appear the cycle after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("rsp appeared too early");

   // reset empties the output stage
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind sheared_periodic_box_wrap spbw_checker u_spbw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .wrapped_y (rsp_if.wrapped_y)
);

### dv/tb.sv
`timescale 1ns / 1ps
// Bench for the sheared periodic box wrap.
// Directed table first, then randomized phases; every accepted word is
// predicted here and compared field by field against what comes back.
module tb;
   import spbw_pkg::*;

   // Step budget per wrap; must track the block's default.
   localparam int WRAP_BUDGET = MAX_WRAPS_DEF;

   // Indexes past the register file; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam logic signed [POS_W-1:0] P_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0] P_MIN = 32'sh8000_0000;
   localparam logic signed [POS_W-1:0] P_ONE = 32'sh0001_0000;
   localparam longint POS_MAX_L = 64'sd2147483647;
   localparam longint POS_MIN_L = -64'sd2147483648;

   localparam int N_PHASES        = 8;
   localparam int WORDS_PER_PHASE = 104;
   localparam int TAIL_CYCLES     = 30;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic                    oor;
      logic                    last;
   } wrap_result_type;

   typedef struct {
      logic [LEN_W-1:0]        len_x;
      logic [LEN_W-1:0]        len_y;
      logic [LEN_W-1:0]        len_z;
      logic [1:0]              shear_axis;
      logic signed [POS_W-1:0] shear_off;
      logic                    two_dim;
   } box_cfg_type;

   typedef enum logic {
      ROW_CSR,
      ROW_POS
   } row_kind_type;

   // One table row is either a register write or a particle word.
   // typed: the expected result is spelled out in the row.
   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   wdata;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      logic                    last;
      logic                    typed;
      wrap_result_type         want;
   } stim_row_type;

   localparam wrap_result_type NO_WANT = '0;
   localparam int N_DIR = 44;

   stim_row_type dir_tbl [N_DIR] = '{
      // reset box of 1.0 on every axis, no shear
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b1,
        '{32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0}},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, -32'sd1, -32'sd1, -32'sd1, 1'b1, 1'b1,
        '{32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF, 1'b0, 1'b1}},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, P_ONE, P_ONE, P_ONE, 1'b0, 1'b1,
        '{32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0}},
      // far out: budget runs dry, value stops where it got to
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, P_MAX, P_MAX, P_MAX, 1'b1, 1'b1,
        '{32'sh7FFB_FFFF, 32'sh7FFB_FFFF, 32'sh7FFB_FFFF, 1'b1, 1'b1}},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, P_MIN, P_MIN, P_MIN, 1'b0, 1'b1,
        '{32'sh8004_0000, 32'sh8004_0000, 32'sh8004_0000, 1'b1, 1'b0}},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0003_8000, -32'sh0002_4000, 32'sh0000_FFFF,
        1'b0, 1'b0, NO_WANT},
      // writes past the register file are dropped
      '{ROW_CSR, REG_SPARE_LO, 32'h0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_SPARE_HI, 32'hFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, -32'sd1, -32'sd1, -32'sd1, 1'b0, 1'b1,
        '{32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF, 1'b0, 1'b0}},
      // widest x box, bit 31 of the write masked off
      '{ROW_CSR, REG_BOX_LEN_X, 32'hFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_BOX_LEN_Y, 32'h0004_0000, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_BOX_LEN_Z, 32'h0003_0000, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, P_MAX, P_MAX, P_MAX, 1'b1, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0000_8000, -32'sh0005_0000, -32'sh0005_0000,
        1'b0, 1'b0, NO_WANT},
      // shear on y
      '{ROW_CSR, REG_SHEAR_AXIS, 32'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_SHEAR_OFFSET, 32'h0001_8000, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0000_1000, -32'sh0001_0000, 32'sh0001_0000,
        1'b0, 1'b0, NO_WANT},
      // narrow x box so the shift pushes x out and the repair wrap runs
      '{ROW_CSR, REG_BOX_LEN_X, 32'h0002_0000, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0001_8000, 32'sh0009_0000, 32'sh0001_0000,
        1'b1, 1'b0, NO_WANT},
      // shear axis three acts as none
      '{ROW_CSR, REG_SHEAR_AXIS, 32'hFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0001_8000, 32'sh0009_0000, 32'sh0001_0000,
        1'b0, 1'b0, NO_WANT},
      // shear on z, first in 2-D mode (no shear, z untouched), then 3-D
      '{ROW_CSR, REG_SHEAR_AXIS, 32'h2, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_TWO_DIM_MODE, 32'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0000_8000, 32'sh0000_8000, P_MIN,
        1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_TWO_DIM_MODE, 32'h0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0000_8000, 32'sh0000_8000, P_MIN,
        1'b1, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0000_8000, 32'sh0000_8000, 32'sh0005_0000,
        1'b0, 1'b0, NO_WANT},
      // tiny boxes with the largest offsets: x leaves 32 bits and saturates
      '{ROW_CSR, REG_BOX_LEN_X, 32'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_BOX_LEN_Y, 32'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_BOX_LEN_Z, 32'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_SHEAR_AXIS, 32'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_SHEAR_OFFSET, 32'h7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, P_MAX, -32'sd1, 32'sh0, 1'b1, 1'b1,
        '{P_MAX, 32'sh0, 32'sh0, 1'b1, 1'b1}},
      '{ROW_CSR, REG_SHEAR_OFFSET, 32'h8000_0000, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, P_MIN, -32'sd1, 32'sh0, 1'b0, 1'b1,
        '{P_MIN, 32'sh0, 32'sh0, 1'b1, 1'b0}},
      // zero-length box: coordinate passes, flag up
      '{ROW_CSR, REG_BOX_LEN_X, 32'h0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_SHEAR_AXIS, 32'h0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sd12345, 32'sh0, 32'sh0, 1'b1, 1'b1,
        '{32'sd12345, 32'sh0, 32'sh0, 1'b1, 1'b1}},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, -32'sd7, 32'sh0, 32'sh0, 1'b0, 1'b1,
        '{-32'sd7, 32'sh0, 32'sh0, 1'b1, 1'b0}},
      // zero-length y box still counts steps and shears x
      '{ROW_CSR, REG_BOX_LEN_X, 32'h0001_0000, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_BOX_LEN_Y, 32'h0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_SHEAR_AXIS, 32'h1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_CSR, REG_SHEAR_OFFSET, 32'h0001_0000, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0, NO_WANT},
      '{ROW_POS, REG_BOX_LEN_X, 32'h0, 32'sh0, 32'sd5, 32'sh0, 1'b0, 1'b0, NO_WANT}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   spbw_req_if req_bus ();
   spbw_rsp_if rsp_bus ();

   sheared_periodic_box_wrap u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted results, oldest first.
   wrap_result_type wrapped_q [$];
   box_cfg_type     shadow_cfg;

   int  n_errors      = 0;
   int  n_words       = 0;
   int  n_flagged     = 0;
   int  n_settings    = 1;
   bit  cfg_dirty     = 1'b0;
   int  req_gap_max   = 16;
   int  rsp_stall_max = 16;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      n_errors++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
   endtask

   // One axis: add or subtract the box length until in [0, len), at most
   // WRAP_BUDGET steps. Returns net steps (+1 add, -1 subtract).
   function automatic longint wrap_coord(inout longint v, input longint len,
                                         inout bit oor);
      longint net;
      net = 0;
      for (int k = 0; k < WRAP_BUDGET; k++) begin
         if (v < 0) begin
            v   += len;
            net += 1;
         end else if (v >= len) begin
            v   -= len;
            net -= 1;
         end else begin
            break;
         end
      end
      if (v < 0 || v >= len)
         oor = 1'b1;
      return net;
   endfunction

   function automatic wrap_result_type predict_wrap(input logic signed [POS_W-1:0] px,
                                                    input logic signed [POS_W-1:0] py,
                                                    input logic signed [POS_W-1:0] pz,
                                                    input logic lp);
      longint          x, y, z, net;
      bit              oor, moved, sh_y, sh_z;
      wrap_result_type r;
      x     = px;
      y     = py;
      z     = pz;
      oor   = 1'b0;
      moved = 1'b0;
      sh_y  = (shadow_cfg.shear_axis == SHEAR_ON_Y);
      sh_z  = (shadow_cfg.shear_axis == SHEAR_ON_Z) && !shadow_cfg.two_dim;

      void'(wrap_coord(x, longint'(shadow_cfg.len_x), oor));
      net = wrap_coord(y, longint'(shadow_cfg.len_y), oor);
      if (sh_y && net != 0) begin
         x     += net * longint'(shadow_cfg.shear_off);
         moved  = 1'b1;
      end
      if (!shadow_cfg.two_dim) begin
         net = wrap_coord(z, longint'(shadow_cfg.len_z), oor);
         if (sh_z && net != 0) begin
            x     += net * longint'(shadow_cfg.shear_off);
            moved  = 1'b1;
         end
      end
      // repair pass: only when a shear step actually moved x
      if (moved)
         void'(wrap_coord(x, longint'(shadow_cfg.len_x), oor));
      if (x > POS_MAX_L)
         x = POS_MAX_L;
      if (x < POS_MIN_L)
         x = POS_MIN_L;

      r.x    = x[31:0];
      r.y    = y[31:0];
      r.z    = z[31:0];
      r.oor  = oor;
      r.last = lp;
      return r;
   endfunction

   // Register write plus the matching update of the shadow copy.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_BOX_LEN_X:    shadow_cfg.len_x      = d[LEN_W-1:0];
         REG_BOX_LEN_Y:    shadow_cfg.len_y      = d[LEN_W-1:0];
         REG_BOX_LEN_Z:    shadow_cfg.len_z      = d[LEN_W-1:0];
         REG_SHEAR_AXIS:   shadow_cfg.shear_axis = d[1:0];
         REG_SHEAR_OFFSET: shadow_cfg.shear_off  = d;
         REG_TWO_DIM_MODE: shadow_cfg.two_dim    = d[0];
         default: ;
      endcase
      cfg_dirty = 1'b1;
      @(posedge clock);
   endtask

   // Stop sending and hold until every predicted word has come back.
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (wrapped_q.size() != 0)
         @(posedge clock);
   endtask

   // Present one particle word, wait for the handshake, log the prediction,
   // then idle a random number of cycles. valid stays high on a zero gap.
   task automatic send_pos(input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] py,
                           input logic signed [POS_W-1:0] pz,
                           input logic lp, input bit typed, input wrap_result_type want);
      wrap_result_type w;
      int              gap;
      if (cfg_dirty) begin
         n_settings++;
         cfg_dirty = 1'b0;
      end
      req_bus.valid         <= 1'b1;
      req_bus.pos_x         <= px;
      req_bus.pos_y         <= py;
      req_bus.pos_z         <= pz;
      req_bus.last_particle <= lp;
      do @(posedge clock); while (!req_bus.ready);
      w = typed ? want : predict_wrap(px, py, pz, lp);
      wrapped_q.push_back(w);
      n_words++;
      if (w.oor)
         n_flagged++;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Coordinate mostly within a few box lengths of the box, sometimes raw
   // noise or a range extreme.
   function automatic logic signed [POS_W-1:0] pick_coord(input logic [LEN_W-1:0] len);
      longint v;
      case ($urandom_range(0, 9))
         0: v = $signed($urandom());
         1: begin
            case ($urandom_range(0, 3))
               0:       v = P_MAX;
               1:       v = P_MIN;
               2:       v = 0;
               default: v = -1;
            endcase
         end
         default: begin
            v = (longint'($urandom_range(0, 6)) - 3) * longint'(len);
            if (len != 0)
               v += longint'($urandom_range(0, len - 1));
            else
               v += longint'($urandom_range(0, 8)) - 4;
         end
      endcase
      if (v > POS_MAX_L)
         v = POS_MAX_L;
      if (v < POS_MIN_L)
         v = POS_MIN_L;
      return v[31:0];
   endfunction

   // Box length write data; bit 31 random to exercise the mask.
   function automatic logic [CSR_DATA_W-1:0] pick_len();
      logic [LEN_W-1:0] len;
      case ($urandom_range(0, 9))
         0:       len = 31'h7FFF_FFFF;
         1:       len = $urandom_range(0, 1);
         2:       len = $urandom();
         default: len = $urandom_range(1, 64) << 12;
      endcase
      return ($urandom() & 32'h8000_0000) | {1'b0, len};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_offset();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom();
         default: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
      endcase
   endfunction

   // Result side: random stall before each word, sometimes none.
   initial begin
      int hold;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = $urandom_range(0, rsp_stall_max);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Checker: every accepted result word against the oldest prediction.
   always @(posedge clock) begin : chk_blk
      wrap_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (wrapped_q.size() == 0) begin
            report_mismatch("unexpected word x", rsp_bus.wrapped_x, 32'h0);
         end else begin
            want = wrapped_q.pop_front();
            if (rsp_bus.wrapped_x !== want.x)
               report_mismatch("wrapped_x", rsp_bus.wrapped_x, want.x);
            if (rsp_bus.wrapped_y !== want.y)
               report_mismatch("wrapped_y", rsp_bus.wrapped_y, want.y);
            if (rsp_bus.wrapped_z !== want.z)
               report_mismatch("wrapped_z", rsp_bus.wrapped_z, want.z);
            if (rsp_bus.out_of_reach !== want.oor)
               report_mismatch("out_of_reach", rsp_bus.out_of_reach, want.oor);
            if (rsp_bus.last_out !== want.last)
               report_mismatch("last_out", rsp_bus.last_out, want.last);
         end
      end
   end

   initial begin
      // everything known from time zero; reset values mirrored in the shadow
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_index             <= REG_BOX_LEN_X;
      csr_wdata             <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.pos_x         <= '0;
      req_bus.pos_y         <= '0;
      req_bus.pos_z         <= '0;
      req_bus.last_particle <= 1'b0;
      shadow_cfg.len_x      = 31'h1 << FRAC_BITS_DEF;
      shadow_cfg.len_y      = 31'h1 << FRAC_BITS_DEF;
      shadow_cfg.len_z      = 31'h1 << FRAC_BITS_DEF;
      shadow_cfg.shear_axis = 2'd0;
      shadow_cfg.shear_off  = '0;
      shadow_cfg.two_dim    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Register rows only once the block has gone quiet.
      for (int i = 0; i < N_DIR; i++) begin
         if (dir_tbl[i].kind == ROW_CSR) begin
            wait_drain();
            write_reg(dir_tbl[i].idx, dir_tbl[i].wdata);
         end else begin
            send_pos(dir_tbl[i].px, dir_tbl[i].py, dir_tbl[i].pz, dir_tbl[i].last,
                     dir_tbl[i].typed, dir_tbl[i].want);
         end
      end

      // Random phases: fresh register set each phase, all six written.
      // Some phases run back to back with no idling on the request or the result side.
      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_drain();
         write_reg(REG_BOX_LEN_X, pick_len());
         write_reg(REG_BOX_LEN_Y, pick_len());
         write_reg(REG_BOX_LEN_Z, pick_len());
         write_reg(REG_SHEAR_AXIS, ($urandom() & ~32'h3) | $urandom_range(0, 3));
         write_reg(REG_SHEAR_OFFSET, pick_offset());
         write_reg(REG_TWO_DIM_MODE, ($urandom() & ~32'h1) | $urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
         req_gap_max   = (ph % 3 == 1) ? 0 : 16;
         rsp_stall_max = (ph % 4 == 2) ? 0 : 16;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            // now and then let the pipe run dry mid-phase
            if (n == WORDS_PER_PHASE / 2 || $urandom_range(0, 59) == 0)
               wait_drain();
            send_pos(pick_coord(shadow_cfg.len_x), pick_coord(shadow_cfg.len_y),
                     pick_coord(shadow_cfg.len_z), $urandom_range(0, 1), 1'b0, NO_WANT);
         end
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d particle words over %0d register settings", n_words, n_settings);
      $display("%0d words predicted out of reach, %0d mismatches", n_flagged, n_errors);
      if (n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
